FILE: design/vpv_pkg.sv
`timescale 1ns / 1ps
// vpv_pkg: shared types, constants and helpers of the vertex projection block
// no dependencies

package vpv_pkg;

    // fixed point format and working widths
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int ACC_W     = TERM_W + 2;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int SIZE_W    = 16;
    localparam int MAP_W     = DATA_W + 1 + SIZE_W + 1;

    // matrix store
    localparam int ENTRIES   = 32;
    localparam int ADDR_W    = 5;

    // divider length
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W    = 6;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // configuration reset values
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 16'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 16'd1080;

    // datapath commands from the controller
    typedef struct packed {
        logic       load_we;
        logic       load_pos;
        logic       mac_issue;
        logic       mac_phase;
        logic [1:0] mac_row;
        logic [1:0] mac_col;
        logic       div_start;
        logic       clamp;
        logic       map_mul;
        logic       out_load;
    } vpv_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic div_done;
    } vpv_status_t;

    // clamped quotient plus one, ready for the viewport multiply
    typedef struct packed {
        logic                      ovf;
        logic signed [DATA_W:0]    plus_one;
    } vpv_clamp_t;

    // apply sign to an unsigned quotient, clamp it to DATA_W bits, add 1.0
    function automatic vpv_clamp_t clamp_quot(input logic [NUM_W-1:0] qm, input logic neg);
        logic [NUM_W-1:0]       lim;
        logic [DATA_W-1:0]      mag;
        logic signed [DATA_W:0] val;
        vpv_clamp_t             res;
        lim = neg ? (NUM_W'(1) << (DATA_W - 1)) : ((NUM_W'(1) << (DATA_W - 1)) - NUM_W'(1));
        res.ovf = (qm > lim);
        mag = res.ovf ? lim[DATA_W-1:0] : qm[DATA_W-1:0];
        val = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        res.plus_one = val + $signed((DATA_W + 1)'(1) << FRAC_BITS);
        return res;
    endfunction

endpackage

FILE: design/vertex_projection_viewport.sv
`timescale 1ns / 1ps
// vertex_projection_viewport: top level, perspective projection and viewport mapping
// depends on vpv_pkg, vpv_ctrl, vpv_datapath

// A load request (cmd 0) writes one Q16.16 matrix entry in the cycle it is taken
// and leaves busy low; it gives no result. A project request (cmd 1) runs 32
// serial multiply-accumulates through the matrix store (view then projection),
// two parallel 48-step bit-serial divisions, then the viewport multiply; done
// pulses for one cycle at the end of the sequence, with screen_x, screen_y,
// zero_depth and saturated valid in that cycle only. The sequence
// length is set by the single store read port and the one-bit-per-cycle
// divider. busy is low again in the done cycle, so the next request may be
// taken there. The receiver cannot stall: done is not held. Configuration
// writes are taken any cycle but are meant for idle periods.

module vertex_projection_viewport
    import vpv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     cmd,
    input  logic [ADDR_W-1:0]        entry_index,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    input  logic signed [DATA_W-1:0] point_z,
    input  logic signed [DATA_W-1:0] point_w,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [SIZE_W-1:0]        cfg_data,
    output logic                     done,
    output logic signed [DATA_W-1:0] screen_x,
    output logic signed [DATA_W-1:0] screen_y,
    output logic                     zero_depth,
    output logic                     saturated
);

    vpv_cmd_t    ctl;
    vpv_status_t stat;

    // controller
    vpv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // datapath
    vpv_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_w     (point_w),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .zero_depth  (zero_depth),
        .saturated   (saturated)
    );

    // a result never appears while a request is still in progress
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // a result follows only a project sequence
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a project request");

endmodule

FILE: design/vpv_ram.sv
`timescale 1ns / 1ps
// vpv_ram: generic single write port, single read port ram with registered read
// no dependencies

module vpv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/vpv_div.sv
`timescale 1ns / 1ps
// vpv_div: unsigned restoring divider, one quotient bit per cycle
// depends on vpv_pkg

module vpv_div
    import vpv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DATA_W-1:0] den,
    output logic              done,
    output logic [NUM_W-1:0]  quotient
);

    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              ge;

    // one trial subtraction
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // done is a single cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    // a finished division leaves the divider idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !run_reg)
        else $error("divider still running at done");

endmodule

FILE: design/vpv_datapath.sv
`timescale 1ns / 1ps
// vpv_datapath: matrix store, multiply-accumulate pipeline, dividers, viewport map
// depends on vpv_pkg, vpv_ram, vpv_div

module vpv_datapath
    import vpv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  vpv_cmd_t                 ctl,
    output vpv_status_t              stat,
    input  logic [ADDR_W-1:0]        entry_index,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    input  logic signed [DATA_W-1:0] point_z,
    input  logic signed [DATA_W-1:0] point_w,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [SIZE_W-1:0]        cfg_data,
    output logic                     done,
    output logic signed [DATA_W-1:0] screen_x,
    output logic signed [DATA_W-1:0] screen_y,
    output logic                     zero_depth,
    output logic                     saturated
);

    logic [SIZE_W-1:0]        width_reg, height_reg;
    logic [ENTRIES-1:0]       valid_reg;
    logic [ADDR_W-1:0]        raddr;
    logic [DATA_W-1:0]        rdata;
    logic signed [DATA_W-1:0] pos_reg [4];
    logic signed [DATA_W-1:0] q_reg [4];
    logic signed [DATA_W-1:0] r_reg [4];

    // pipeline tags
    logic                     a_vld_reg, a_phase_reg, ent_vld_reg;
    logic [1:0]               a_row_reg, a_col_reg;
    logic                     b_vld_reg, b_phase_reg;
    logic [1:0]               b_row_reg, b_col_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] entry_val, vec_val;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DATA_W-1:0] acc_sat;
    logic                     acc_ovf;
    logic                     flag_reg, dflag_reg;

    // division and mapping
    logic [DATA_W-1:0]        mag0, mag1, mag3;
    logic [NUM_W-1:0]         qx, qy;
    logic                     done_x, done_y;
    vpv_clamp_t               cl_x, cl_y;
    logic signed [DATA_W:0]   cx_reg, cy_reg;
    logic signed [MAP_W-1:0]  mx_reg, my_reg;
    logic signed [DATA_W-1:0] sx_val, sy_val;
    logic                     ovf_x, ovf_y, zero_w;
    logic                     done_reg, zero_reg, sat_reg;
    logic signed [DATA_W-1:0] sx_reg, sy_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // matrix store: view entries sit in the upper half
    assign raddr = {~ctl.mac_phase, ctl.mac_row, ctl.mac_col};

    vpv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ctl.load_we),
        .waddr (entry_index),
        .wdata (entry_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // per-entry written marks, unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            ent_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load_we)
            begin
                valid_reg[entry_index] <= 1'b1;
            end
            ent_vld_reg <= valid_reg[raddr];
        end
    end

    // point capture
    always_ff @(posedge clk)
    begin
        if (ctl.load_pos)
        begin
            pos_reg[0] <= point_x;
            pos_reg[1] <= point_y;
            pos_reg[2] <= point_z;
            pos_reg[3] <= point_w;
        end
    end

    // multiply stage
    always_comb
    begin
        entry_val = ent_vld_reg ? $signed(rdata) : '0;
        vec_val   = a_phase_reg ? q_reg[a_col_reg] : pos_reg[a_col_reg];
        prod_next = entry_val * vec_val;
    end

    // accumulate stage, term floored by the fraction shift
    always_comb
    begin
        acc_next = ((b_col_reg == 2'd0) ? '0 : acc_reg)
                 + $signed({{(ACC_W - TERM_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:FRAC_BITS]});
        acc_ovf  = !((&acc_next[ACC_W-1:DATA_W-1]) || !(|acc_next[ACC_W-1:DATA_W-1]));
        if (!acc_ovf)
        begin
            acc_sat = acc_next[DATA_W-1:0];
        end
        else if (acc_next[ACC_W-1])
        begin
            acc_sat = {1'b1, {(DATA_W - 1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(DATA_W - 1){1'b1}}};
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= ctl.mac_issue;
            b_vld_reg <= a_vld_reg;
        end
    end

    // pipeline payload and row results
    always_ff @(posedge clk)
    begin
        a_phase_reg <= ctl.mac_phase;
        a_row_reg   <= ctl.mac_row;
        a_col_reg   <= ctl.mac_col;
        b_phase_reg <= a_phase_reg;
        b_row_reg   <= a_row_reg;
        b_col_reg   <= a_col_reg;
        prod_reg    <= prod_next;
        if (b_vld_reg)
        begin
            acc_reg <= acc_next;
            if (b_col_reg == 2'd3)
            begin
                if (b_phase_reg)
                begin
                    r_reg[b_row_reg] <= acc_sat;
                end
                else
                begin
                    q_reg[b_row_reg] <= acc_sat;
                end
            end
        end
    end

    // clamp flag of the matrix products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (ctl.load_pos)
        begin
            flag_reg <= 1'b0;
        end
        else if (b_vld_reg && (b_col_reg == 2'd3) && acc_ovf)
        begin
            flag_reg <= 1'b1;
        end
    end

    // divider operands
    assign mag0 = r_reg[0][DATA_W-1] ? DATA_W'(-r_reg[0]) : DATA_W'(r_reg[0]);
    assign mag1 = r_reg[1][DATA_W-1] ? DATA_W'(-r_reg[1]) : DATA_W'(r_reg[1]);
    assign mag3 = r_reg[3][DATA_W-1] ? DATA_W'(-r_reg[3]) : DATA_W'(r_reg[3]);
    assign zero_w = (r_reg[3] == '0);

    vpv_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .num      ({mag0, {FRAC_BITS{1'b0}}}),
        .den      (mag3),
        .done     (done_x),
        .quotient (qx)
    );

    vpv_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .num      ({mag1, {FRAC_BITS{1'b0}}}),
        .den      (mag3),
        .done     (done_y),
        .quotient (qy)
    );

    assign stat.div_done = done_x & done_y;

    // sign and clamp of the quotients, y is negated
    assign cl_x = clamp_quot(qx, r_reg[0][DATA_W-1] ^ r_reg[3][DATA_W-1]);
    assign cl_y = clamp_quot(qy, ~(r_reg[1][DATA_W-1] ^ r_reg[3][DATA_W-1]));

    always_ff @(posedge clk)
    begin
        if (ctl.clamp)
        begin
            cx_reg    <= cl_x.plus_one;
            cy_reg    <= cl_y.plus_one;
            dflag_reg <= cl_x.ovf | cl_y.ovf;
        end
        if (ctl.map_mul)
        begin
            mx_reg <= cx_reg * $signed({1'b0, width_reg});
            my_reg <= cy_reg * $signed({1'b0, height_reg});
        end
    end

    // halve and clamp to the output width
    always_comb
    begin
        ovf_x = !((&mx_reg[MAP_W-1:DATA_W]) || !(|mx_reg[MAP_W-1:DATA_W]));
        ovf_y = !((&my_reg[MAP_W-1:DATA_W]) || !(|my_reg[MAP_W-1:DATA_W]));
        if (!ovf_x)
        begin
            sx_val = mx_reg[DATA_W:1];
        end
        else
        begin
            sx_val = mx_reg[MAP_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
        end
        if (!ovf_y)
        begin
            sy_val = my_reg[DATA_W:1];
        end
        else
        begin
            sy_val = my_reg[MAP_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.out_load;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            zero_reg <= zero_w;
            sx_reg   <= zero_w ? '0 : sx_val;
            sy_reg   <= zero_w ? '0 : sy_val;
            sat_reg  <= flag_reg | (!zero_w & (dflag_reg | ovf_x | ovf_y));
        end
    end

    assign done       = done_reg;
    assign screen_x   = sx_reg;
    assign screen_y   = sy_reg;
    assign zero_depth = zero_reg;
    assign saturated  = sat_reg;

    // a zero depth result always carries zero coordinates
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && zero_reg) |-> (sx_reg == '0) && (sy_reg == '0))
        else $error("zero depth result with nonzero coordinates");

endmodule

FILE: design/vpv_ctrl.sv
`timescale 1ns / 1ps
// vpv_ctrl: sequencer for load and project requests
// depends on vpv_pkg

module vpv_ctrl
    import vpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        cmd,
    input  vpv_status_t stat,
    output vpv_cmd_t    ctl,
    output logic        busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DIVST,
        S_DIV,
        S_CLAMP,
        S_MAP,
        S_OUT
    } state_t;

    state_t     state_reg;
    logic [4:0] cnt_reg;
    logic       accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // commands decoded from state and counter
    always_comb
    begin
        ctl.load_we   = accept && (cmd == CMD_LOAD);
        ctl.load_pos  = accept && (cmd == CMD_PROJECT);
        ctl.mac_issue = (state_reg == S_MAC);
        ctl.mac_phase = cnt_reg[4];
        ctl.mac_row   = cnt_reg[3:2];
        ctl.mac_col   = cnt_reg[1:0];
        ctl.div_start = (state_reg == S_DIVST);
        ctl.clamp     = (state_reg == S_CLAMP);
        ctl.map_mul   = (state_reg == S_MAP);
        ctl.out_load  = (state_reg == S_OUT);
    end

    // state and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept && (cmd == CMD_PROJECT))
                    begin
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        state_reg <= S_DIVST;
                    end
                end
                S_DIVST: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP: state_reg <= S_MAP;
                S_MAP:   state_reg <= S_OUT;
                S_OUT:   state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // division completion moves on to the clamp step
    a_div_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_done) |=> (state_reg == S_CLAMP))
        else $error("division result not taken");

    // a project request always starts the product sequence at entry zero
    a_mac_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_pos |=> (state_reg == S_MAC) && (cnt_reg == 5'd0))
        else $error("product sequence did not start cleanly");

endmodule
